// ----- rtl/lsd_pkg.sv -----
// Shared types and codes for the LED driver serial command decoder.
// No dependencies; imported by lsd_front, lsd_exec and the top level.
`default_nettype none

package lsd_pkg;

   // event codes on req_cmd
   localparam logic [2:0] CMD_STROBE_LOW  = 3'd0;
   localparam logic [2:0] CMD_BYTE        = 3'd1;
   localparam logic [2:0] CMD_READ        = 3'd2;
   localparam logic [2:0] CMD_STROBE_HIGH = 3'd3;
   localparam logic [2:0] CMD_KEY_LOAD    = 3'd4;

   typedef enum logic [2:0] {
      K_STROBE_LOW,
      K_BYTE,
      K_READ,
      K_STROBE_HIGH,
      K_KEY_LOAD,
      K_UNKNOWN
   } kind_type;

   // command group, top two bits of a command byte
   typedef enum logic [1:0] {
      GRP_UNUSED  = 2'b00,
      GRP_MODE    = 2'b01,
      GRP_DISPLAY = 2'b10,
      GRP_ADDR    = 2'b11
   } grp_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_STRAY  = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   // classified transaction handed from front to back
   typedef struct packed {
      kind_type    kind;
      grp_type     group;
      logic [7:0]  data;
      logic [2:0]  key_index;
   } op_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        read_valid;
      logic        ram_write_valid;
      logic [3:0]  ram_write_addr;
      logic [7:0]  ram_write_data;
      logic        display_on;
      logic [2:0]  brightness_level;
      status_type  status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/lsd_fifo.sv -----
// Small synchronous queue with registered count and full/empty flags.
// Generic in width and depth; no package dependencies.
`default_nettype none

module lsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/lsd_front.sv -----
// Front end: accepts input transactions and classifies them into ops.
// Depends on lsd_pkg.
`default_nettype none

module lsd_front
   import lsd_pkg::*;
(
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_cmd,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [2:0] req_key_index,
   input  wire logic       op_full,
   output logic            op_push,
   output op_type          op
);

   kind_type kind;

   always_comb begin
      unique case (req_cmd)
         CMD_STROBE_LOW:  kind = K_STROBE_LOW;
         CMD_BYTE:        kind = K_BYTE;
         CMD_READ:        kind = K_READ;
         CMD_STROBE_HIGH: kind = K_STROBE_HIGH;
         CMD_KEY_LOAD:    kind = K_KEY_LOAD;
         default:         kind = K_UNKNOWN;
      endcase
   end

   assign req_full     = op_full;
   assign op_push      = req_push;
   assign op.kind      = kind;
   assign op.group     = grp_type'(req_data_byte[7:6]);
   assign op.data      = req_data_byte;
   assign op.key_index = req_key_index;

endmodule

`default_nettype wire

// ----- rtl/lsd_exec.sv -----
// Back end: frame state machine, mode/display/address registers, key store.
// Executes one op per cycle into the result queue while that queue is not full. Depends on lsd_pkg.
`default_nettype none

module lsd_exec
   import lsd_pkg::*;
#(
   parameter int RAM_BYTES = 14,
   parameter int KEY_BYTES = 5
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   input  wire op_type op,
   output logic        op_pop,
   input  wire logic   out_full,
   output logic        out_push,
   output rsp_type     out_rsp
);

   localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMD,
      PH_DATA,
      PH_CLOSED
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [3:0]     addr_ff, addr_in;
   logic           fixed_ff, fixed_in;
   logic           keyrd_ff, keyrd_in;
   logic           disp_ff, disp_in;
   logic [2:0]     bright_ff, bright_in;
   logic [7:0]     key_ff [KEY_BYTES];
   logic [7:0]     key_in [KEY_BYTES];
   logic [KIW-1:0] kpos_ff, kpos_in;
   logic           go;

   assign go       = op_valid && !out_full;
   assign op_pop   = go;
   assign out_push = go;

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      fixed_in  = fixed_ff;
      keyrd_in  = keyrd_ff;
      disp_in   = disp_ff;
      bright_in = bright_ff;
      kpos_in   = kpos_ff;
      key_in    = key_ff;
      out_rsp   = '0;
      out_rsp.status = ST_OK;

      unique case (op.kind)
         K_STROBE_LOW:  phase_in = PH_CMD;
         K_STROBE_HIGH: phase_in = PH_IDLE;
         K_BYTE: begin
            if (phase_ff == PH_CMD) begin
               unique case (op.group)
                  GRP_MODE: begin
                     keyrd_in = op.data[1];
                     fixed_in = op.data[2];
                     if (op.data[1]) begin
                        kpos_in  = '0;
                        phase_in = PH_DATA;
                     end else begin
                        phase_in = PH_CLOSED;
                     end
                  end
                  GRP_DISPLAY: begin
                     disp_in   = op.data[3];
                     bright_in = op.data[2:0];
                     phase_in  = PH_CLOSED;
                  end
                  GRP_ADDR: begin
                     addr_in  = op.data[3:0];
                     phase_in = PH_DATA;
                  end
                  default: begin
                     phase_in       = PH_CLOSED;
                     out_rsp.status = ST_UNUSED;
                  end
               endcase
            end else if (phase_ff == PH_DATA && !keyrd_ff) begin
               if ({1'b0, addr_ff} < 5'(RAM_BYTES)) begin
                  out_rsp.ram_write_valid = 1'b1;
                  out_rsp.ram_write_addr  = addr_ff;
                  out_rsp.ram_write_data  = op.data;
                  if (!fixed_ff) begin
                     addr_in = addr_ff + 4'd1;
                  end
               end else begin
                  out_rsp.status = ST_RANGE;
               end
            end else begin
               out_rsp.status = ST_STRAY;
            end
         end
         K_READ: begin
            if (phase_ff == PH_DATA && keyrd_ff) begin
               out_rsp.read_data  = key_ff[kpos_ff];
               out_rsp.read_valid = 1'b1;
               kpos_in = (kpos_ff == KIW'(KEY_BYTES - 1)) ? '0 : kpos_ff + KIW'(1);
            end else begin
               out_rsp.status = ST_STRAY;
            end
         end
         K_KEY_LOAD: begin
            if ({1'b0, op.key_index} < 4'(KEY_BYTES)) begin
               key_in[op.key_index[KIW-1:0]] = op.data;
            end else begin
               out_rsp.status = ST_RANGE;
            end
         end
         default: out_rsp.status = ST_UNUSED;
      endcase

      // reported display settings include this transaction's update
      out_rsp.display_on       = disp_in;
      out_rsp.brightness_level = bright_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         addr_ff   <= '0;
         fixed_ff  <= 1'b0;
         keyrd_ff  <= 1'b0;
         disp_ff   <= 1'b0;
         bright_ff <= '0;
         kpos_ff   <= '0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            key_ff[i] <= '0;
         end
      end else if (go) begin
         phase_ff  <= phase_in;
         addr_ff   <= addr_in;
         fixed_ff  <= fixed_in;
         keyrd_ff  <= keyrd_in;
         disp_ff   <= disp_in;
         bright_ff <= bright_in;
         kpos_ff   <= kpos_in;
         key_ff    <= key_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/led_driver_serial_command_decoder_top.sv -----
// Top level of the LED driver serial command decoder.
// Uses lsd_pkg, lsd_front, lsd_fifo and lsd_exec.
//
// Input channel (req_*): one event per transaction (strobe low/high, received
// byte, byte read request, key scan load). A transaction is taken on a clock
// edge with req_push high and req_full low.
// Result channel (rsp_*): exactly one result per input transaction, in order.
// The oldest result sits on the rsp_ ports while rsp_empty is low and is
// taken on an edge with rsp_pop high.
// Path: an accepted transaction is registered in the op queue, then the back
// end executes it into the result queue, which presents it on the rsp_ ports
// until it is popped.
// Throughput: one transaction per cycle while results are popped; the back
// end executes one op per cycle against the frame state.
// Stall: when rsp_pop stays low the two-entry result queue fills, the back
// end stops, the two-entry op queue fills and req_full rises.
// Reset (synchronous): both queues empty, frame idle, modes, display,
// address, key read position and key bytes cleared.
// Display RAM contents are reported through the ram_write_* result fields.
`default_nettype none

module led_driver_serial_command_decoder_top
   import lsd_pkg::*;
#(
   parameter int RAM_BYTES = 14,
   parameter int KEY_BYTES = 5
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_cmd,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [2:0] req_key_index,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_read_valid,
   output logic            rsp_ram_write_valid,
   output logic [3:0]      rsp_ram_write_addr,
   output logic [7:0]      rsp_ram_write_data,
   output logic            rsp_display_on,
   output logic [2:0]      rsp_brightness_level,
   output logic [1:0]      rsp_status
);

   localparam int OPW  = $bits(op_type);
   localparam int RSPW = $bits(rsp_type);

   op_type           op_w, op_q;
   logic [OPW-1:0]   op_bits;
   logic             op_push, op_full, op_empty, op_pop;
   rsp_type          rsp_w, rsp_q;
   logic [RSPW-1:0]  rsp_bits;
   logic             out_push, out_full;

   lsd_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_key_index (req_key_index),
      .op_full       (op_full),
      .op_push       (op_push),
      .op            (op_w)
   );

   lsd_fifo #(.WIDTH(OPW), .DEPTH(2)) u_op_q (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_w),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_bits),
      .empty     (op_empty)
   );

   assign op_q = op_type'(op_bits);

   lsd_exec #(.RAM_BYTES(RAM_BYTES), .KEY_BYTES(KEY_BYTES)) u_exec (
      .clock    (clock),
      .reset    (reset),
      .op_valid (!op_empty),
      .op       (op_q),
      .op_pop   (op_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_rsp  (rsp_w)
   );

   lsd_fifo #(.WIDTH(RSPW), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (rsp_w),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_q                = rsp_type'(rsp_bits);
   assign rsp_read_data        = rsp_q.read_data;
   assign rsp_read_valid       = rsp_q.read_valid;
   assign rsp_ram_write_valid  = rsp_q.ram_write_valid;
   assign rsp_ram_write_addr   = rsp_q.ram_write_addr;
   assign rsp_ram_write_data   = rsp_q.ram_write_data;
   assign rsp_display_on       = rsp_q.display_on;
   assign rsp_brightness_level = rsp_q.brightness_level;
   assign rsp_status           = rsp_q.status;

endmodule

`default_nettype wire

// ----- rtl/lsd_checker.sv -----
// Port-level checks for the LED driver serial command decoder, bound to the
// top level. Depends on nothing but the top level's ports and parameters.
`default_nettype none

module lsd_checker #(
   parameter int RAM_BYTES = 14
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_push,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_read_valid,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_ram_write_valid,
   input wire logic [3:0] rsp_ram_write_addr,
   input wire logic [7:0] rsp_ram_write_data
);

   // queues come out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // no result appears without an earlier accepted transaction
   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && rsp_empty && !(req_push && !req_full)
       && !$past(req_push && !req_full)) |=> rsp_empty)
      else $error("result appeared without an input transaction");

   // a transaction either reads keys or writes display RAM, never both
   a_one_effect : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_read_valid && rsp_ram_write_valid))
      else $error("read and write in one result");

   // write fields are zero unless a write happened, address in range otherwise
   a_write_fields : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_ram_write_valid ? ({1'b0, rsp_ram_write_addr} < 5'(RAM_BYTES))
                      : (rsp_ram_write_addr == 4'd0 && rsp_ram_write_data == 8'd0)))
      else $error("bad display RAM write fields");

   a_read_fields : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_read_valid) |-> (rsp_read_data == 8'd0))
      else $error("read data without a read");

endmodule

bind led_driver_serial_command_decoder_top lsd_checker #(.RAM_BYTES(RAM_BYTES)) u_lsd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_push            (req_push),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_read_valid      (rsp_read_valid),
   .rsp_read_data       (rsp_read_data),
   .rsp_ram_write_valid (rsp_ram_write_valid),
   .rsp_ram_write_addr  (rsp_ram_write_addr),
   .rsp_ram_write_data  (rsp_ram_write_data)
);

`default_nettype wire
